FILE: hdl/gha_pkg.sv
// Shared types and constants of the generational handle allocator.
package gha_pkg;

  // Field widths of a handle
  localparam int IndexBits   = 10;
  localparam int GenBits     = 8;
  localparam int MinFreeBits = 11;
  localparam int IdxMask     = (1 << IndexBits) - 1;
  localparam logic [MinFreeBits-1:0] MinFreeReset = MinFreeBits'(1024);

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CHECK   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [IndexBits-1:0] handle_index;
    logic [GenBits-1:0]   handle_generation;
  } gha_req_t;

  typedef struct packed {
    status_e              status;
    logic [IndexBits-1:0] out_index;
    logic [GenBits-1:0]   out_generation;
    logic                 alive;
  } gha_rsp_t;

  // Control from the sequencer to the free-slot queue
  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
  } gha_queue_ctl_t;

endpackage

FILE: hdl/gha_free_queue.sv
// FIFO of freed slot indices held in a synchronous memory.
module gha_free_queue import gha_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gha_queue_ctl_t                   ctl_i,
  input  logic [IndexBits-1:0]             push_data_i,
  output logic [IndexBits-1:0]             rd_data_o,
  output logic [$clog2(MAX_SLOTS+1)-1:0]   count_o
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  logic [IndexBits-1:0] mem_q [MAX_SLOTS];
  logic [IndexBits-1:0] rd_data_q;
  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        tail_q, tail_d;
  logic [CW-1:0]        count_q, count_d;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.pop) begin
      head_d = (head_q == AW'(MAX_SLOTS - 1)) ? '0 : head_q + AW'(1);
    end
    if (ctl_i.push) begin
      tail_d = (tail_q == AW'(MAX_SLOTS - 1)) ? '0 : tail_q + AW'(1);
    end
    if (ctl_i.push && !ctl_i.pop) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.pop && !ctl_i.push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Write at the tail, read the head into a registered output
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= push_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

FILE: hdl/generational_handle_allocator.sv
// Top level of the generational handle allocator.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-----------------------------
//  in       | input     | in_valid_i / in_stall_o   | in_req_i  (opcode, handle)
//  out      | output    | out_valid_o / out_stall_i | out_rsp_o (status, handle)
//  cfg      | input     | cfg_we_i                  | cfg_wdata_i (min_free)
//
// The accept edge reads the generation memory and the queue head; in S_EXEC
// the request is decided, written back and loaded into the output register
// once it is free. A create that reuses a freed slot also passes S_REUSE, as
// its generation is read from the generation memory only once the queue head is known.
// Reset clears the counters and queue pointers; the memories are not cleared.
// A stalled result waits in the output register; the next request is taken
// as soon as the current one has been loaded there.
module generational_handle_allocator import gha_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MinFreeBits-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  gha_req_t               in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output gha_rsp_t               out_rsp_o
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int XW = (IndexBits > AW) ? IndexBits : AW;
  localparam int MW = (CW > MinFreeBits) ? CW : MinFreeBits;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_REUSE = 2'd2;

  logic [1:0]             state_q, state_d;
  gha_req_t               req_q;
  logic [MinFreeBits-1:0] min_free_q;
  logic [AW-1:0]          opened_q, opened_d;
  logic                   out_valid_q;
  gha_rsp_t               out_rsp_q, rsp_d;

  logic [GenBits-1:0]     gen_mem_q [MAX_SLOTS];
  logic [GenBits-1:0]     gen_rd_q;
  logic                   gen_rd_en;
  logic [AW-1:0]          gen_rd_addr;
  logic                   gen_wr_en;
  logic [AW-1:0]          gen_wr_addr;
  logic [GenBits-1:0]     gen_wr_data;

  gha_queue_ctl_t         qctl;
  logic [IndexBits-1:0]   q_head_idx;
  logic [CW-1:0]          q_count;

  logic                   in_acc;
  logic                   out_free;
  logic                   commit;
  logic                   go_reuse;
  logic                   reuse;
  logic                   full;
  logic                   alive;
  logic [IndexBits-1:0]   fresh_idx;

  // Map a 1-based slot index to a memory address
  function automatic logic [AW-1:0] idx_to_addr(input logic [IndexBits-1:0] idx);
    logic [XW-1:0] ext;
    ext = XW'(idx) - XW'(1);
    return ext[AW-1:0];
  endfunction

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Decode the held request
  assign reuse = (q_count != '0) && (MW'(q_count) >= MW'(min_free_q));
  assign full  = (opened_q == AW'(MAX_SLOTS - 1)) || (XW'(opened_q) >= XW'(IdxMask));
  assign alive = (req_q.handle_index != '0)
              && (XW'(req_q.handle_index) <= XW'(opened_q))
              && (gen_rd_q == req_q.handle_generation);
  assign fresh_idx = IndexBits'(XW'(opened_q) + XW'(1));

  assign go_reuse = (state_q == S_EXEC) && (req_q.opcode == OP_CREATE) && reuse;
  assign commit   = out_free && (((state_q == S_EXEC) && !go_reuse) || (state_q == S_REUSE));

  // Build the result and the write-back
  always_comb begin
    rsp_d       = '{status: ST_OK, out_index: '0, out_generation: '0, alive: 1'b0};
    opened_d    = opened_q;
    gen_wr_en   = 1'b0;
    gen_wr_addr = opened_q;
    gen_wr_data = '0;
    qctl        = '{rd: in_acc, push: 1'b0, pop: 1'b0};
    if (state_q == S_REUSE) begin
      rsp_d.out_index      = q_head_idx;
      rsp_d.out_generation = gen_rd_q;
      qctl.pop             = commit;
    end else begin
      unique case (req_q.opcode)
        OP_CREATE: begin
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            rsp_d.out_index = fresh_idx;
            gen_wr_en       = commit;
            if (commit) begin
              opened_d = opened_q + AW'(1);
            end
          end
        end
        OP_DESTROY: begin
          if (alive) begin
            rsp_d.alive = 1'b1;
            gen_wr_en   = commit;
            gen_wr_addr = idx_to_addr(req_q.handle_index);
            gen_wr_data = gen_rd_q + GenBits'(1);
            qctl.push   = commit && (q_count != CW'(MAX_SLOTS));
          end else begin
            rsp_d.status = ST_INVALID;
          end
        end
        OP_CHECK: begin
          rsp_d.alive = alive;
        end
        OP_NOP: begin
          rsp_d.alive = 1'b0;
        end
      endcase
    end
  end

  // Sequence one request at a time
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC: begin
        if (go_reuse) begin
          state_d = S_REUSE;
        end else if (commit) begin
          state_d = S_IDLE;
        end
      end
      S_REUSE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_free_q  <= MinFreeReset;
      opened_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      opened_q <= opened_d;
      if (cfg_we_i) begin
        min_free_q <= cfg_wdata_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (commit) begin
      out_rsp_q <= rsp_d;
    end
  end

  // Generation memory: one write and one registered read per cycle
  assign gen_rd_en   = in_acc || go_reuse;
  assign gen_rd_addr = in_acc ? idx_to_addr(in_req_i.handle_index) : idx_to_addr(q_head_idx);

  always_ff @(posedge clk_i) begin
    if (gen_wr_en) begin
      gen_mem_q[gen_wr_addr] <= gen_wr_data;
    end
    if (gen_rd_en) begin
      gen_rd_q <= gen_mem_q[gen_rd_addr];
    end
  end

  gha_free_queue #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_free_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (qctl),
    .push_data_i (req_q.handle_index),
    .rd_data_o   (q_head_idx),
    .count_o     (q_count)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: hdl/gha_checker.sv
// Port-level checker for the generational handle allocator, bound to the top level.
module gha_checker import gha_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input gha_rsp_t out_rsp_o
);

  // Take one request at a time: stall right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in work");

  // Drop index and generation on any failure
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_OK) |->
      (out_rsp_o.out_index == '0) && (out_rsp_o.out_generation == '0) && !out_rsp_o.alive)
    else $error("failed request carries handle data");

  // Liveness answers never carry a created handle
  a_alive_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.alive |->
      (out_rsp_o.out_index == '0) && (out_rsp_o.out_generation == '0))
    else $error("alive result carries a handle");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

FILE: tb/generational_handle_allocator_test.sv
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 100ps

module generational_handle_allocator_test;
  import gha_pkg::*;

  localparam int SlotCount  = 1024;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  // Mirror of the allocator state; predicts one response per accepted request
  class allocator_mirror;
    logic [MinFreeBits-1:0] min_free;
    logic [GenBits-1:0]     slot_gen [SlotCount];
    logic [IndexBits-1:0]   free_slots [SlotCount];
    int unsigned            opened;
    int unsigned            head;
    int unsigned            tail;
    int unsigned            queued;
    int unsigned            failures;
    gha_rsp_t               pending_rsp [$];

    function new();
      min_free = MinFreeReset;
      opened   = 0;
      head     = 0;
      tail     = 0;
      queued   = 0;
      failures = 0;
    endfunction

    function bit is_live(logic [IndexBits-1:0] idx, logic [GenBits-1:0] gen);
      if (idx == 0 || idx > opened) return 1'b0;
      return slot_gen[idx - 1] == gen;
    endfunction

    function int unsigned pending();
      return pending_rsp.size();
    endfunction

    // Pick any opened slot at its current generation: alive whenever a slot is open
    function gha_req_t live_handle(opcode_e op);
      gha_req_t r;
      r = '0;
      r.opcode = op;
      if (opened > 0) begin
        r.handle_index      = IndexBits'($urandom_range(opened, 1));
        r.handle_generation = slot_gen[r.handle_index - 1];
      end else begin
        r.handle_generation = GenBits'($urandom_range(255, 0));
      end
      return r;
    endfunction

    // Same slot, any other generation: never alive
    function gha_req_t stale_handle(opcode_e op);
      gha_req_t r;
      r = live_handle(op);
      r.handle_generation = r.handle_generation + GenBits'($urandom_range(255, 1));
      return r;
    endfunction

    function void note_request(gha_req_t r);
      gha_rsp_t    rsp;
      int unsigned fresh;
      rsp = '0;
      unique case (r.opcode)
        OP_CREATE: begin
          if (queued > 0 && queued >= min_free) begin
            // reuse the oldest freed slot
            rsp.out_index = free_slots[head];
            head = (head + 1) % SlotCount;
            queued--;
            if (rsp.out_index != 0 && rsp.out_index <= opened)
              rsp.out_generation = slot_gen[rsp.out_index - 1];
          end else begin
            fresh = opened + 1;
            if (fresh >= SlotCount || fresh > IdxMask) begin
              rsp.status = ST_FULL;
            end else begin
              slot_gen[fresh - 1] = '0;
              opened = fresh;
              rsp.out_index = IndexBits'(fresh);
            end
          end
        end
        OP_DESTROY: begin
          if (is_live(r.handle_index, r.handle_generation)) begin
            rsp.alive = 1'b1;
            slot_gen[r.handle_index - 1] = slot_gen[r.handle_index - 1] + 1'b1;
            // drop the push once the queue is full
            if (queued < SlotCount) begin
              free_slots[tail] = r.handle_index;
              tail = (tail + 1) % SlotCount;
              queued++;
            end
          end else begin
            rsp.status = ST_INVALID;
          end
        end
        OP_CHECK: rsp.alive = is_live(r.handle_index, r.handle_generation);
        default: ;
      endcase
      pending_rsp.insert(pending_rsp.size(), rsp);
    endfunction

    function void check_response(gha_rsp_t got);
      gha_rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response %h with no request outstanding", got);
        failures++;
        return;
      end
      want = pending_rsp[0];
      pending_rsp.delete(0);
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.out_index !== want.out_index) begin
        $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
        failures++;
      end
      if (got.out_generation !== want.out_generation) begin
        $error("out_generation: expected %0d, got %0d", want.out_generation,
               got.out_generation);
        failures++;
      end
      if (got.alive !== want.alive) begin
        $error("alive: expected %0d, got %0d", want.alive, got.alive);
        failures++;
      end
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [MinFreeBits-1:0] cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  gha_req_t               in_req_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  gha_rsp_t               out_rsp_o;

  logic            idle_en     = 1'b1;
  logic            long_hold   = 1'b0;
  int unsigned     hold_count  = 0;
  int unsigned     cycle_count = 0;
  allocator_mirror mirror;

  generational_handle_allocator #(
    .MAX_SLOTS(SlotCount)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check responses; stall at random, or hold off for a long stretch once
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mirror.check_response(out_rsp_o);
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (long_hold && hold_count < HoldCycles) begin
      hold_count  = hold_count + 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99, 0) < 8);
    end
  end

  // Offer one request, with random gaps ahead of it, and hold until taken
  task automatic send_request(input gha_req_t r);
    while (idle_en && $urandom_range(99, 0) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.note_request(r);
  endtask

  task automatic send_op(input opcode_e op, input int idx, input int gen);
    gha_req_t r;
    r.opcode            = op;
    r.handle_index      = IndexBits'(idx);
    r.handle_generation = GenBits'(gen);
    send_request(r);
  endtask

  // Stop offering and wait for every outstanding response
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_min_free(input int value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= MinFreeBits'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mirror.min_free = MinFreeBits'(value);
  endtask

  // Mostly well-formed traffic on live handles, some stale handles and noise
  function automatic gha_req_t random_request();
    int unsigned pick;
    gha_req_t    r;
    pick = $urandom_range(99, 0);
    r.opcode            = OP_CREATE;
    r.handle_index      = IndexBits'($urandom_range(IdxMask, 0));
    r.handle_generation = GenBits'($urandom_range(255, 0));
    if (pick >= 85)      r.opcode = opcode_e'($urandom_range(3, 0));
    else if (pick >= 80) r = mirror.stale_handle(pick[0] ? OP_DESTROY : OP_CHECK);
    else if (pick >= 65) r = mirror.live_handle(OP_CHECK);
    else if (pick >= 35) r = mirror.live_handle(OP_DESTROY);
    return r;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  initial begin
    gha_req_t r;
    int       n;
    mirror = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: null and unopened handles, fresh slots, reuse, duplicates
    write_min_free(0);
    send_op(OP_CHECK, 0, 0);
    send_op(OP_CHECK, IdxMask, 255);
    send_op(OP_CREATE, 0, 0);
    send_op(OP_CREATE, IdxMask, 255);
    send_op(OP_CHECK, 1, 0);
    send_op(OP_CHECK, 1, 255);
    send_op(OP_DESTROY, 2, 1);
    send_op(OP_DESTROY, 0, 0);
    send_op(OP_DESTROY, 1, 0);
    send_op(OP_DESTROY, 1, 1);
    send_op(OP_CHECK, 1, 2);
    send_op(OP_CREATE, 0, 0);
    send_op(OP_CREATE, 0, 0);
    send_op(OP_CREATE, 0, 0);
    send_op(OP_NOP, IdxMask, 255);
    send_op(OP_DESTROY, IdxMask, 255);
    send_op(OP_CHECK, 2, 0);
    send_op(OP_CHECK, 3, 0);

    // Random traffic with a long receiver hold and one full pause
    write_min_free(3);
    for (int i = 0; i < 200; i++) begin
      if (i == 80) long_hold <= 1'b1;
      if (i == 150) drain();
      send_request(random_request());
    end

    // Open every slot and fill the free queue, first stretch without idling
    write_min_free(1024);
    idle_en <= 1'b0;
    n = 0;
    while (mirror.opened < SlotCount - 1 || mirror.queued < SlotCount) begin
      if (n == 400) idle_en <= 1'b1;
      if ($urandom_range(49, 0) == 0)
        r = mirror.live_handle(OP_CHECK);
      else if (mirror.opened < SlotCount - 1 &&
               (mirror.queued >= SlotCount - 1 || $urandom_range(1, 0) == 1))
        r = mirror.live_handle(OP_CREATE);
      else if (mirror.queued < SlotCount)
        r = mirror.live_handle(OP_DESTROY);
      else
        r = mirror.live_handle(OP_CREATE);
      send_request(r);
      n++;
    end
    idle_en <= 1'b1;
    // Queue full: generation advances, push dropped; then reuse and exhaustion
    repeat (3) send_request(mirror.live_handle(OP_DESTROY));
    repeat (4) send_request(mirror.live_handle(OP_CREATE));

    write_min_free(1023);
    random_phase(40);
    write_min_free(0);
    random_phase(40);

    drain();
    repeat (8) @(posedge clk_i);
    if (mirror.pending() != 0) begin
      $error("%0d responses never arrived", mirror.pending());
      mirror.failures++;
    end
    if (mirror.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
